// File: src/lbp_pkg.sv
// ----------------------------------------------------------------------------
// LED blink pattern package
// Shared types, command codes and constant pattern tables.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int NUM_STATUS   = 12;
    localparam int NUM_PRIO     = 5;
    localparam int MASK_W       = 12;
    localparam int CNT_W        = 16;
    localparam int PAT_W        = 4;
    localparam int CODE_W       = 4;
    localparam int FUNC_W       = 3;
    localparam int PERIOD_W     = 10;

    localparam logic [CNT_W-1:0]    ON_ALWAYS     = 16'hffff;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET  = 10'd10;
    localparam logic [PAT_W-1:0]    PAT_IDLE      = 4'd0;
    localparam logic                SEL_BLUE      = 1'b0;
    localparam logic                SEL_RED       = 1'b1;

    localparam logic [FUNC_W-1:0] FUNC_TICK  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_SET   = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RESET = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 3'd3;

    typedef logic [PAT_W-1:0] prio_list_t [NUM_PRIO];

    localparam prio_list_t PRIO_BLUE = '{4'd7, 4'd8, 4'd9, 4'd10, 4'd11};
    localparam prio_list_t PRIO_RED  = '{4'd1, 4'd3, 4'd4, 4'd5, 4'd2};

    typedef struct packed {
        logic              tick;
        logic              set_bit;
        logic              reset_bit;
        logic              clear_all;
        logic [CODE_W-1:0] code;
    } lbp_cmd_t;

    typedef struct packed {
        logic [MASK_W-1:0] mask_next;
        logic              pin_next;
        logic              mask_zero;
        logic              active;
    } lbp_led_stat_t;

    function automatic logic [CNT_W-1:0] pat_on(input logic [PAT_W-1:0] idx);
        logic [CNT_W-1:0] v;
        case (idx)
            4'd1:    v = 16'd30;
            4'd2:    v = 16'd150;
            4'd4:    v = 16'd50;
            4'd5:    v = 16'd50;
            4'd6:    v = 16'hffff;
            4'd7:    v = 16'd200;
            4'd8:    v = 16'd500;
            4'd9:    v = 16'd1000;
            4'd10:   v = 16'd1000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] pat_off(input logic [PAT_W-1:0] idx);
        logic [CNT_W-1:0] v;
        case (idx)
            4'd1:    v = 16'd30;
            4'd2:    v = 16'hf000;
            4'd4:    v = 16'd50;
            4'd5:    v = 16'd50;
            4'd7:    v = 16'd200;
            4'd8:    v = 16'd500;
            4'd9:    v = 16'd1000;
            4'd10:   v = 16'd5000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

// File: src/lbp_if.sv
// ----------------------------------------------------------------------------
// LED blink pattern channels
// Valid/ready channels for command words, result words and configuration.
// ----------------------------------------------------------------------------
interface lbp_in_if;
    logic                         valid;
    logic                         ready;
    logic [lbp_pkg::FUNC_W-1:0]   func;
    logic                         led_sel;
    logic [lbp_pkg::CODE_W-1:0]   status_code;

    modport source (output valid, output func, output led_sel, output status_code,
                    input ready);
    modport sink   (input valid, input func, input led_sel, input status_code,
                    output ready);
endinterface

interface lbp_out_if;
    logic                         valid;
    logic                         ready;
    logic                         pin_blue;
    logic                         pin_red;
    logic                         busy_res;
    logic [lbp_pkg::MASK_W-1:0]   mask_readback;

    modport source (output valid, output pin_blue, output pin_red, output busy_res,
                    output mask_readback, input ready);
    modport sink   (input valid, input pin_blue, input pin_red, input busy_res,
                    input mask_readback, output ready);
endinterface

interface lbp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [lbp_pkg::PERIOD_W-1:0] tick_period_ms;

    modport source (output valid, output tick_period_ms, input ready);
    modport sink   (input valid, input tick_period_ms, output ready);
endinterface

// File: src/lbp_led.sv
// ----------------------------------------------------------------------------
// LED blink pattern, one LED
// Status mask, pattern choice, millisecond counter and pin level of one LED.
// ----------------------------------------------------------------------------
module lbp_led (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           led_id,
    input  logic                           upd,
    input  lbp_pkg::lbp_cmd_t              cmd,
    input  logic [lbp_pkg::PERIOD_W-1:0]   tick_period,
    output lbp_pkg::lbp_led_stat_t         stat
);
    import lbp_pkg::*;

    logic [MASK_W-1:0] mask_reg,    mask_next;
    logic [CNT_W-1:0]  counter_reg, counter_next;
    logic [PAT_W-1:0]  pattern_reg, pattern_next;
    logic              pin_reg,     pin_next;

    logic [MASK_W-1:0] code_hot;
    logic              set_eff;
    logic              reset_eff;
    logic              found;
    logic [PAT_W-1:0]  prio_code;
    logic [PAT_W-1:0]  tick_idx;
    logic [CNT_W-1:0]  on_ms;
    logic [CNT_W-1:0]  off_ms;
    logic [CNT_W:0]    period_sum;
    logic [CNT_W-1:0]  cnt_sum;

    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            code_hot[i] = (cmd.code == CODE_W'(i));
        end
    end

    assign set_eff   = cmd.set_bit && ((mask_reg & code_hot) == '0) && (code_hot != '0);
    assign reset_eff = cmd.reset_bit && ((mask_reg & code_hot) != '0);

    assign tick_idx   = (pattern_reg < PAT_W'(NUM_STATUS)) ? pattern_reg : PAT_IDLE;
    assign on_ms      = pat_on(tick_idx);
    assign off_ms     = pat_off(tick_idx);
    assign period_sum = {1'b0, on_ms} + {1'b0, off_ms};
    assign cnt_sum    = counter_reg + CNT_W'(tick_period);

    always_comb
    begin
        mask_next    = mask_reg;
        counter_next = counter_reg;
        pattern_next = pattern_reg;
        pin_next     = pin_reg;
        found        = 1'b0;
        prio_code    = PAT_IDLE;

        if (set_eff || reset_eff)
        begin
            mask_next = set_eff ? (mask_reg | code_hot) : (mask_reg & ~code_hot);
            if (mask_next == '0)
            begin
                pattern_next = PAT_IDLE;
            end
            else
            begin
                for (int k = 0; k < NUM_PRIO; k++)
                begin
                    prio_code = (led_id == SEL_RED) ? PRIO_RED[k] : PRIO_BLUE[k];
                    if (!found && mask_next[prio_code])
                    begin
                        found = 1'b1;
                        if (pattern_reg != prio_code)
                        begin
                            pattern_next = prio_code;
                            counter_next = '0;
                        end
                    end
                end
            end
        end
        else if (cmd.clear_all)
        begin
            mask_next = '0;
        end
        else if (cmd.tick)
        begin
            counter_next = cnt_sum;
            if (on_ms == '0)
            begin
                pin_next = 1'b1;
            end
            else if (on_ms == ON_ALWAYS)
            begin
                pin_next = 1'b0;
            end
            else if ({1'b0, cnt_sum} > period_sum)
            begin
                counter_next = '0;
            end
            else if (cnt_sum > on_ms)
            begin
                pin_next = 1'b1;
            end
            else
            begin
                pin_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg    <= '0;
            counter_reg <= '0;
            pattern_reg <= PAT_IDLE;
            pin_reg     <= 1'b1;
        end
        else if (upd)
        begin
            mask_reg    <= mask_next;
            counter_reg <= counter_next;
            pattern_reg <= pattern_next;
            pin_reg     <= pin_next;
        end
    end

    assign stat.mask_next = mask_next;
    assign stat.pin_next  = pin_next;
    assign stat.mask_zero = (mask_reg == '0);
    assign stat.active    = set_eff || reset_eff;

endmodule

// File: src/led_blink_pattern_controller_core.sv
// ----------------------------------------------------------------------------
// LED blink pattern controller
// Two active-low LEDs driven by priority-chosen blink patterns.
// ----------------------------------------------------------------------------
// The result word of an accepted command word is registered and offered in the cycle after it is accepted.
// Throughput: one word per cycle while the result side is ready; the output register frees as it is taken.
// Both LED units update in the same cycle, each from two adds and a few compares.
// Reset: asynchronous; masks and counters clear, LEDs dark, tick period 10 ms.
module led_blink_pattern_controller_core (
    input  logic      clk,
    input  logic      rst_n,
    lbp_in_if.sink    in_ch,
    lbp_out_if.source out_ch,
    lbp_cfg_if.sink   cfg_ch
);
    import lbp_pkg::*;

    logic [PERIOD_W-1:0] tick_period_reg;
    logic                running_reg, running_next;
    logic                out_valid_reg;
    logic                pin_blue_reg;
    logic                pin_red_reg;
    logic                busy_reg;
    logic [MASK_W-1:0]   mask_reg;

    logic                accept;
    lbp_cmd_t            cmd_base;
    lbp_cmd_t            cmd_blue;
    lbp_cmd_t            cmd_red;
    lbp_led_stat_t       stat_blue;
    lbp_led_stat_t       stat_red;

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = !out_valid_reg || out_ch.ready;
    assign accept       = in_ch.valid && in_ch.ready;

    assign cmd_base.tick      = (in_ch.func == FUNC_TICK) && running_reg;
    assign cmd_base.set_bit   = (in_ch.func == FUNC_SET);
    assign cmd_base.reset_bit = (in_ch.func == FUNC_RESET);
    assign cmd_base.clear_all = (in_ch.func == FUNC_CLEAR);
    assign cmd_base.code      = in_ch.status_code;

    always_comb
    begin
        cmd_blue = cmd_base;
        cmd_red  = cmd_base;
        if (in_ch.led_sel != SEL_BLUE)
        begin
            cmd_blue.set_bit   = 1'b0;
            cmd_blue.reset_bit = 1'b0;
            cmd_blue.clear_all = 1'b0;
        end
        if (in_ch.led_sel != SEL_RED)
        begin
            cmd_red.set_bit   = 1'b0;
            cmd_red.reset_bit = 1'b0;
            cmd_red.clear_all = 1'b0;
        end
    end

    lbp_led u_unit_blue (
        .clk         (clk),
        .rst_n       (rst_n),
        .led_id      (SEL_BLUE),
        .upd         (accept),
        .cmd         (cmd_blue),
        .tick_period (tick_period_reg),
        .stat        (stat_blue)
    );

    lbp_led u_unit_red (
        .clk         (clk),
        .rst_n       (rst_n),
        .led_id      (SEL_RED),
        .upd         (accept),
        .cmd         (cmd_red),
        .tick_period (tick_period_reg),
        .stat        (stat_red)
    );

    always_comb
    begin
        running_next = running_reg;
        if (stat_blue.active || stat_red.active)
        begin
            running_next = 1'b1;
        end
        else if (cmd_base.tick && stat_blue.mask_zero && stat_red.mask_zero)
        begin
            running_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= PERIOD_RESET;
            running_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                tick_period_reg <= cfg_ch.tick_period_ms;
            end
            if (accept)
            begin
                running_reg   <= running_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pin_blue_reg <= stat_blue.pin_next;
            pin_red_reg  <= stat_red.pin_next;
            busy_reg     <= running_next;
            mask_reg     <= (in_ch.led_sel == SEL_RED) ? stat_red.mask_next
                                                       : stat_blue.mask_next;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.pin_blue      = pin_blue_reg;
    assign out_ch.pin_red       = pin_red_reg;
    assign out_ch.busy_res      = busy_reg;
    assign out_ch.mask_readback = mask_reg;

endmodule

// File: tb/led_blink_pattern_controller_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED blink pattern controller testbench
// Runs a table of directed command words and then random phases, each
// under its own tick period, against a cycle-free model of the two LEDs.
// Both channel sides idle at random, and one long result stall backs up
// the command channel. Every result word is checked field by field.
// ----------------------------------------------------------------------------
module led_blink_pattern_controller_core_test;

    import lbp_pkg::*;

    localparam logic [FUNC_W-1:0] FUNC_READ  = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_SPARE = 3'd7;
    localparam int PHASE_ITEMS     = 230;
    localparam int NUM_PHASES      = 6;
    localparam int HOLD_OFF_CYCLES = 60;
    localparam int STALL_LIMIT     = 1000;
    localparam int MAX_PRINTED     = 40;

    typedef struct packed {
        logic              pin_blue;
        logic              pin_red;
        logic              busy;
        logic [MASK_W-1:0] mask;
    } led_word_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              led;
        logic [CODE_W-1:0] code;
        logic              typed;
        led_word_t         want;
    } step_row_t;

    localparam led_word_t NO_WANT = '0;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    lbp_in_if  cmd_ch ();
    lbp_out_if res_ch ();
    lbp_cfg_if cfg_ch ();

    led_blink_pattern_controller_core i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (cmd_ch),
        .out_ch (res_ch),
        .cfg_ch (cfg_ch)
    );

    int unsigned on_ms  [12] = '{0, 30, 150, 0, 50, 50, 16'hffff, 200, 500, 1000, 1000, 0};
    int unsigned off_ms [12] = '{0, 30, 16'hf000, 0, 50, 50, 0, 200, 500, 1000, 5000, 0};
    int unsigned prio_order [2][5] = '{'{7, 8, 9, 10, 11}, '{1, 3, 4, 5, 2}};

    logic [MASK_W-1:0] led_mask    [2];
    logic [CNT_W-1:0]  led_count   [2];
    logic [PAT_W-1:0]  led_pattern [2];
    logic              led_pin     [2];
    logic              leds_running;
    int unsigned       period_ms;

    led_word_t expected_words [$];
    step_row_t directed_steps [$];
    int        mismatch_count = 0;
    int        idle_run = 0;
    bit        zero_gaps = 1'b0;
    bit        hold_off_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic log_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic void pick_pattern(input int led);
        int unsigned s;
        if (led_mask[led] == '0)
        begin
            led_pattern[led] = PAT_IDLE;
            return;
        end
        for (int k = 0; k < NUM_PRIO; k++)
        begin
            s = prio_order[led][k];
            if (led_mask[led][s])
            begin
                if (led_pattern[led] != s)
                begin
                    led_pattern[led] = PAT_W'(s);
                    led_count[led]   = '0;
                end
                return;
            end
        end
    endfunction

    function automatic void advance_led(input int led);
        int unsigned idx;
        int unsigned on_t;
        int unsigned off_t;
        int unsigned cnt;
        idx = led_pattern[led];
        if (idx >= NUM_STATUS)
            idx = 0;
        on_t  = on_ms[idx];
        off_t = off_ms[idx];
        cnt   = (led_count[led] + period_ms) & 32'hffff;
        if (on_t == 0)
            led_pin[led] = 1'b1;
        else if (on_t == ON_ALWAYS)
            led_pin[led] = 1'b0;
        else if (cnt > on_t + off_t)
            cnt = 0;
        else if (cnt > on_t)
            led_pin[led] = 1'b1;
        else
            led_pin[led] = 1'b0;
        led_count[led] = cnt[CNT_W-1:0];
    endfunction

    function automatic led_word_t next_led_word(input logic [FUNC_W-1:0] f, input logic led,
                                                input logic [CODE_W-1:0] code);
        logic [MASK_W-1:0] bitv;
        int                sel;
        sel  = int'(led);
        bitv = (code < NUM_STATUS) ? (MASK_W'(1) << code) : '0;
        case (f)
            FUNC_TICK:
            begin
                if (leds_running)
                begin
                    advance_led(0);
                    advance_led(1);
                    if (led_mask[0] == '0 && led_mask[1] == '0)
                        leds_running = 1'b0;
                end
            end
            FUNC_SET:
            begin
                if (bitv != '0 && (led_mask[sel] & bitv) == '0)
                begin
                    led_mask[sel] = led_mask[sel] | bitv;
                    pick_pattern(sel);
                    leds_running = 1'b1;
                end
            end
            FUNC_RESET:
            begin
                if ((led_mask[sel] & bitv) != '0)
                begin
                    led_mask[sel] = led_mask[sel] & ~bitv;
                    pick_pattern(sel);
                    leds_running = 1'b1;
                end
            end
            FUNC_CLEAR:
                led_mask[sel] = '0;
            default:
                ;
        endcase
        return '{led_pin[0], led_pin[1], leds_running, led_mask[sel]};
    endfunction

    task automatic send_cmd(input logic [FUNC_W-1:0] f, input logic led,
                            input logic [CODE_W-1:0] code, output led_word_t pred);
        int gap;
        gap = zero_gaps ? 0 : $urandom_range(0, 7);
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.func        <= f;
        cmd_ch.led_sel     <= led;
        cmd_ch.status_code <= code;
        do @(posedge clk); while (!cmd_ch.ready);
        pred = next_led_word(f, led, code);
    endtask

    task automatic quiesce();
        cmd_ch.valid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_tick_period(input int unsigned v);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.tick_period_ms <= v[PERIOD_W-1:0];
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        period_ms = v;
    endtask

    always @(posedge clk)
    begin
        if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
            idle_run <= 0;
        else
            idle_run <= idle_run + 1;
        if (idle_run >= STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin : receiver
        int        gap;
        led_word_t want;
        res_ch.ready <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            gap = zero_gaps ? 0 : $urandom_range(0, 7);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                gap = HOLD_OFF_CYCLES;
            end
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!res_ch.valid);
            if (expected_words.size() == 0)
                log_mismatch($sformatf("unexpected word, mask %03h", res_ch.mask_readback));
            else
            begin
                want = expected_words.pop_front();
                if (res_ch.pin_blue !== want.pin_blue)
                    log_mismatch($sformatf("pin_blue %b, want %b",
                                           res_ch.pin_blue, want.pin_blue));
                if (res_ch.pin_red !== want.pin_red)
                    log_mismatch($sformatf("pin_red %b, want %b",
                                           res_ch.pin_red, want.pin_red));
                if (res_ch.busy_res !== want.busy)
                    log_mismatch($sformatf("busy_res %b, want %b",
                                           res_ch.busy_res, want.busy));
                if (res_ch.mask_readback !== want.mask)
                    log_mismatch($sformatf("mask_readback %03h, want %03h",
                                           res_ch.mask_readback, want.mask));
            end
        end
    end

    initial
    begin : stimulus
        led_word_t         pred;
        logic [FUNC_W-1:0] f;
        logic              led;
        logic [CODE_W-1:0] code;
        int                sel;
        int unsigned       period;

        cmd_ch.valid          <= 1'b0;
        cmd_ch.func           <= FUNC_TICK;
        cmd_ch.led_sel        <= SEL_BLUE;
        cmd_ch.status_code    <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.tick_period_ms <= PERIOD_RESET;

        for (int i = 0; i < 2; i++)
        begin
            led_mask[i]    = '0;
            led_count[i]   = '0;
            led_pattern[i] = PAT_IDLE;
            led_pin[i]     = 1'b1;
        end
        leds_running = 1'b0;
        period_ms    = PERIOD_RESET;

        directed_steps.push_back('{FUNC_READ, SEL_BLUE, 4'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 12'h000}});
        directed_steps.push_back('{FUNC_TICK, SEL_RED, 4'd0, 1'b1, '{1'b1, 1'b1, 1'b0, 12'h000}});
        directed_steps.push_back('{FUNC_SET, SEL_BLUE, 4'd7, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h080}});
        directed_steps.push_back('{FUNC_SET, SEL_BLUE, 4'd7, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h080}});
        directed_steps.push_back('{FUNC_SET, SEL_RED, 4'd12, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h000}});
        directed_steps.push_back('{FUNC_SET, SEL_RED, 4'd15, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h000}});
        directed_steps.push_back('{FUNC_RESET, SEL_RED, 4'd12, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h000}});
        directed_steps.push_back('{FUNC_SET, SEL_RED, 4'd2, 1'b1, '{1'b1, 1'b1, 1'b1, 12'h004}});
        directed_steps.push_back('{FUNC_TICK, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_SET, SEL_RED, 4'd1, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_SET, SEL_BLUE, 4'd11, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_TICK, SEL_RED, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_TICK, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_RESET, SEL_BLUE, 4'd7, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_RESET, SEL_BLUE, 4'd3, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_TICK, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_RESET, SEL_BLUE, 4'd11, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_SET, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_SET, SEL_RED, 4'd11, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_RESET, SEL_RED, 4'd11, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_CLEAR, SEL_RED, 4'd5, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_CLEAR, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_TICK, SEL_RED, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_TICK, SEL_BLUE, 4'd0, 1'b0, NO_WANT});
        directed_steps.push_back('{FUNC_SPARE, SEL_RED, 4'd15, 1'b0, NO_WANT});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[i])
        begin
            send_cmd(directed_steps[i].func, directed_steps[i].led,
                     directed_steps[i].code, pred);
            expected_words.push_back(directed_steps[i].typed ? directed_steps[i].want : pred);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            quiesce();
            case (phase)
                0:       period = 1000;
                1:       period = 1;
                2:       period = $urandom_range(2, 60);
                default: period = $urandom_range(1, 1000);
            endcase
            write_tick_period(period);
            zero_gaps = (phase == 1 || phase == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 && n == 40)
                    hold_off_req = 1'b1;
                sel = $urandom_range(0, 99);
                if (sel < 45)
                    f = FUNC_TICK;
                else if (sel < 65)
                    f = FUNC_SET;
                else if (sel < 80)
                    f = FUNC_RESET;
                else if (sel < 84)
                    f = FUNC_CLEAR;
                else
                    f = FUNC_W'($urandom_range(FUNC_READ, FUNC_SPARE));
                led = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 9) == 0)
                    code = CODE_W'($urandom_range(NUM_STATUS, 15));
                else if ($urandom_range(0, 1))
                    code = CODE_W'(prio_order[led][$urandom_range(0, NUM_PRIO - 1)]);
                else
                    code = CODE_W'($urandom_range(0, NUM_STATUS - 1));
                send_cmd(f, led, code, pred);
                expected_words.push_back(pred);
            end
            zero_gaps = 1'b0;
        end

        quiesce();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
